// ===== src/smm_pkg.sv =====
// Shared types and constants for the square matrix multiplier.
package smm_pkg;

    // Default largest matrix dimension
    localparam int MAX_SIZE_DEF = 8;

    // Field widths
    localparam int SIZE_W = 4;
    localparam int ELEM_W = 16;
    localparam int MUL_W  = 2 * ELEM_W;
    localparam int PROD_W = 35;

    // Size register value after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Controller states
    typedef enum logic [0:0] {
        ST_LOAD,
        ST_RUN
    } t_state;

    // Tag that travels with one product term down the datapath
    typedef struct packed {
        logic first_k;
        logic last_k;
        logic last_elem;
    } t_tag;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd_en;
        t_tag tag;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic adv;
    } t_dp_stat;

endpackage

// ===== src/smm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/smm_ctrl.sv =====
// Controller: size register, load counter and the i/j/k sequencer.
module smm_ctrl
    import smm_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF,
    parameter int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_elem_valid,
    output logic              o_elem_stall,
    input  logic              i_cfg_valid,
    input  logic [SIZE_W-1:0] i_cfg_matrix_size,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [ADDR_W-1:0] o_rd_addr_a,
    output logic [ADDR_W-1:0] o_rd_addr_b
);

    localparam int NW     = $clog2(MAX_SIZE + 1);
    localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CW     = $clog2(MAX_SIZE * MAX_SIZE + 1);
    localparam int LCNT_W = $clog2(2 * MAX_SIZE * MAX_SIZE + 1);

    t_state              r_state,    n_state;
    logic [SIZE_W-1:0]   r_size,     n_size;
    logic [LCNT_W-1:0]   r_load_cnt, n_load_cnt;
    logic [IDX_W-1:0]    r_i, n_i, r_j, n_j, r_k, n_k;
    logic [ADDR_W-1:0]   r_a_addr,   n_a_addr;
    logic [ADDR_W-1:0]   r_b_addr,   n_b_addr;
    logic [ADDR_W-1:0]   r_row_base, n_row_base;

    logic [NW-1:0]       n_act;
    logic [IDX_W-1:0]    idx_last;
    logic [CW-1:0]       cells;
    logic [LCNT_W-1:0]   two_cells;
    logic                accept;
    logic                last_i, last_j, last_k;

    // Clamp the configured size to 1..MAX_SIZE
    always_comb begin
        if (r_size == '0) begin
            n_act = NW'(1);
        end else if (r_size > SIZE_W'(MAX_SIZE)) begin
            n_act = NW'(MAX_SIZE);
        end else begin
            n_act = NW'(r_size);
        end
    end

    assign idx_last  = IDX_W'(n_act - NW'(1));
    assign cells     = CW'(CW'(n_act) * CW'(n_act));
    assign two_cells = LCNT_W'(cells) << 1;
    assign accept    = (r_state == ST_LOAD) && i_elem_valid;
    assign last_i    = (r_i == idx_last);
    assign last_j    = (r_j == idx_last);
    assign last_k    = (r_k == idx_last);

    assign o_elem_stall = (r_state != ST_LOAD);
    assign o_rd_addr_a  = r_a_addr;
    assign o_rd_addr_b  = r_b_addr;

    // Next state, counters and datapath commands
    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_load_cnt = r_load_cnt;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_a_addr   = r_a_addr;
        n_b_addr   = r_b_addr;
        n_row_base = r_row_base;
        o_cmd      = '0;
        o_wr_addr  = ADDR_W'(r_load_cnt);

        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    // A first, then B, each row-major
                    if (r_load_cnt < LCNT_W'(cells)) begin
                        o_cmd.wr_a = 1'b1;
                        o_wr_addr  = ADDR_W'(r_load_cnt);
                    end else begin
                        o_cmd.wr_b = 1'b1;
                        o_wr_addr  = ADDR_W'(r_load_cnt - LCNT_W'(cells));
                    end
                    if (r_load_cnt == two_cells - LCNT_W'(1)) begin
                        n_state    = ST_RUN;
                        n_load_cnt = '0;
                        n_i        = '0;
                        n_j        = '0;
                        n_k        = '0;
                        n_a_addr   = '0;
                        n_b_addr   = '0;
                        n_row_base = '0;
                    end else begin
                        n_load_cnt = r_load_cnt + LCNT_W'(1);
                    end
                end
            end
            ST_RUN: begin
                if (i_stat.adv) begin
                    // Issue one A*B term read
                    o_cmd.rd_en         = 1'b1;
                    o_cmd.tag.first_k   = (r_k == '0);
                    o_cmd.tag.last_k    = last_k;
                    o_cmd.tag.last_elem = last_i && last_j;
                    if (!last_k) begin
                        n_k      = r_k + IDX_W'(1);
                        n_a_addr = r_a_addr + ADDR_W'(1);
                        n_b_addr = r_b_addr + ADDR_W'(n_act);
                    end else begin
                        n_k = '0;
                        if (!last_j) begin
                            n_j      = r_j + IDX_W'(1);
                            n_a_addr = r_row_base;
                            n_b_addr = ADDR_W'(r_j) + ADDR_W'(1);
                        end else begin
                            n_j        = '0;
                            n_i        = r_i + IDX_W'(1);
                            n_row_base = r_row_base + ADDR_W'(n_act);
                            n_a_addr   = r_row_base + ADDR_W'(n_act);
                            n_b_addr   = '0;
                            if (last_i) begin
                                n_state = ST_LOAD;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // Size write restarts the load
        if (i_cfg_valid) begin
            n_size     = i_cfg_matrix_size;
            n_load_cnt = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_size     <= SIZE_RESET;
            r_load_cnt <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_a_addr   <= '0;
            r_b_addr   <= '0;
            r_row_base <= '0;
        end else begin
            r_state    <= n_state;
            r_size     <= n_size;
            r_load_cnt <= n_load_cnt;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_a_addr   <= n_a_addr;
            r_b_addr   <= n_b_addr;
            r_row_base <= n_row_base;
        end
    end

    // Load count stays below the end of B while loading
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_load_cnt < two_cells))
        else $error("load count past end of B");

    // Last B element starts the run
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_valid && r_load_cnt == two_cells - LCNT_W'(1))
        |=> (r_state == ST_RUN))
        else $error("run did not start after last B element");

    // Sequencer indices stay inside the matrix
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_i <= idx_last && r_j <= idx_last && r_k <= idx_last))
        else $error("sequencer index out of range");

endmodule

// ===== src/smm_datapath.sv =====
// Datapath: A and B stores, multiply-accumulate pipeline and output register.
module smm_datapath
    import smm_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF,
    parameter int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  t_dp_cmd                  i_cmd,
    input  logic [ADDR_W-1:0]        i_wr_addr,
    input  logic [ADDR_W-1:0]        i_rd_addr_a,
    input  logic [ADDR_W-1:0]        i_rd_addr_b,
    output t_dp_stat                 o_stat,
    input  logic                     i_prod_stall,
    output logic                     o_prod_valid,
    output logic signed [PROD_W-1:0] o_product_element,
    output logic                     o_last_of_matrix
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;

    logic [ELEM_W-1:0]        a_rdata, b_rdata;
    logic                     adv;
    logic                     r_s1_vld, r_s2_vld, r_out_vld;
    t_tag                     r_s1_tag, r_s2_tag;
    logic signed [MUL_W-1:0]  r_s2_prod;
    logic signed [PROD_W-1:0] r_acc, r_out;
    logic                     r_out_last;
    logic signed [PROD_W-1:0] prod_ext, sum;

    // Freeze the whole pipeline while a finished result is held
    assign adv        = !(r_out_vld && i_prod_stall);
    assign o_stat.adv = adv;

    smm_ram #(
        .WIDTH  (ELEM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (i_wr_addr),
        .i_wdata (i_element_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr_a),
        .o_rdata (a_rdata)
    );

    smm_ram #(
        .WIDTH  (ELEM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (i_wr_addr),
        .i_wdata (i_element_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr_b),
        .o_rdata (b_rdata)
    );

    // Sign-extend the product and accumulate
    assign prod_ext = {{(PROD_W - MUL_W){r_s2_prod[MUL_W-1]}}, r_s2_prod};
    assign sum      = (r_s2_tag.first_k ? '0 : r_acc) + prod_ext;

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_vld <= i_cmd.rd_en;
                r_s2_vld <= r_s1_vld;
            end
            if (adv && r_s2_vld && r_s2_tag.last_k) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_prod_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_tag  <= i_cmd.tag;
            r_s2_tag  <= r_s1_tag;
            r_s2_prod <= $signed(a_rdata) * $signed(b_rdata);
            if (r_s2_vld) begin
                r_acc <= sum;
                if (r_s2_tag.last_k) begin
                    r_out      <= sum;
                    r_out_last <= r_s2_tag.last_elem;
                end
            end
        end
    end

    assign o_prod_valid      = r_out_vld;
    assign o_product_element = r_out;
    assign o_last_of_matrix  = r_out_last;

    // A completed sum always lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2_vld && r_s2_tag.last_k) |=> r_out_vld)
        else $error("finished sum not loaded into output register");

    // A frozen pipeline keeps its product
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && r_s2_vld) |=> ($stable(r_s2_prod) && r_s2_vld))
        else $error("product changed while pipeline frozen");

    // No read issued while the pipeline is frozen
    a_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> !i_cmd.rd_en)
        else $error("read issued while pipeline frozen");

endmodule

// ===== src/square_matrix_multiply.sv =====
// Top level of the square matrix multiplier: controller plus datapath.
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+---------------------------------------
//  element   | i_elem_valid / o_elem_stall       | i_element_value
//  product   | o_prod_valid / i_prod_stall       | o_product_element, o_last_of_matrix
//  config    | i_cfg_valid / o_cfg_ready         | i_cfg_matrix_size
//
// Loading takes 2*n*n transfers, A then B.
// After the last B element one multiply-accumulate unit issues n*n*n terms, one per cycle while no
// result is stalled; no elements are taken meanwhile. Sums leave via the output register.
// Reset is synchronous, active low; it sets the size to 8 and empties the load.
// A stalled result freezes the multiply-accumulate pipeline until it is taken.
module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_elem_valid,
    output logic                     o_elem_stall,
    input  logic signed [ELEM_W-1:0] i_element_value,
    output logic                     o_prod_valid,
    input  logic                     i_prod_stall,
    output logic signed [PROD_W-1:0] o_product_element,
    output logic                     o_last_of_matrix,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [SIZE_W-1:0]        i_cfg_matrix_size
);

    localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    // Size writes are always taken
    assign o_cfg_ready = 1'b1;

    smm_ctrl #(
        .MAX_SIZE (MAX_SIZE),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_elem_valid      (i_elem_valid),
        .o_elem_stall      (o_elem_stall),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_matrix_size (i_cfg_matrix_size),
        .i_stat            (stat),
        .o_cmd             (cmd),
        .o_wr_addr         (wr_addr),
        .o_rd_addr_a       (rd_addr_a),
        .o_rd_addr_b       (rd_addr_b)
    );

    smm_datapath #(
        .MAX_SIZE (MAX_SIZE),
        .ADDR_W   (ADDR_W)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_element_value   (i_element_value),
        .i_cmd             (cmd),
        .i_wr_addr         (wr_addr),
        .i_rd_addr_a       (rd_addr_a),
        .i_rd_addr_b       (rd_addr_b),
        .o_stat            (stat),
        .i_prod_stall      (i_prod_stall),
        .o_prod_valid      (o_prod_valid),
        .o_product_element (o_product_element),
        .o_last_of_matrix  (o_last_of_matrix)
    );

endmodule
